/* design/ascii_integer_field_parser_assert.svh */
// Assertion macros for the integer field parser checks
`ifndef ASCII_INTEGER_FIELD_PARSER_ASSERT_SVH
`define ASCII_INTEGER_FIELD_PARSER_ASSERT_SVH

// same-cycle implication, clocked and reset-qualified
`define AIFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aifp check failed");

// next-cycle implication, clocked and reset-qualified
`define AIFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aifp check failed");

`endif

/* design/aifp_pkg.sv */
// Shared types and constants of the integer field parser
package aifp_pkg;

  // configuration port
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [1:0] {
    REG_BASE_MODE   = 2'd0,
    REG_WIDTH_LIMIT = 2'd1,
    REG_RESULT_SIZE = 2'd2,
    REG_COLON_PAIR  = 2'd3
  } reg_idx_e;

  // register reset values
  localparam logic [1:0]  RST_BASE_MODE   = 2'd1;
  localparam logic [16:0] RST_WIDTH_LIMIT = 17'h1FFFF;
  localparam logic [2:0]  RST_RESULT_SIZE = 3'd2;
  localparam logic        RST_COLON_PAIR  = 1'b0;

  // bit of width_left that marks an unlimited field
  localparam int unsigned UNLIM_BIT = 16;

  typedef struct packed {
    logic [1:0]  base_mode;
    logic [16:0] width_limit;
    logic [2:0]  result_size;
    logic        colon_pair;
  } cfg_t;

  typedef enum logic [2:0] {
    PH_WS     = 3'd0,
    PH_PREFIX = 3'd1,
    PH_ZERO   = 3'd2,
    PH_RUN1   = 3'd3,
    PH_RUN2   = 3'd4
  } phase_e;

  // per-field state that does not depend on the count width
  typedef struct packed {
    phase_e      phase;
    logic [16:0] width_left;
    logic [63:0] acc;
    logic        negative;
    logic [4:0]  base;
  } ctl_t;

  typedef struct packed {
    logic [63:0] value;
    logic [15:0] matched_count;
    logic        matched;
    logic        consumed;
    logic        at_end;
  } result_t;

endpackage

/* design/aifp_in_if.sv */
// Input character channel
interface aifp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source (output valid, ch, end_of_input, input ready);
  modport sink   (input valid, ch, end_of_input, output ready);
endinterface

/* design/aifp_out_if.sv */
// Result channel
interface aifp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [15:0] matched_count;
  logic        matched;
  logic        consumed;
  logic        at_end;

  modport source (output valid, value, matched_count, matched, consumed, at_end,
                  input ready);
  modport sink   (input valid, value, matched_count, matched, consumed, at_end,
                  output ready);
endinterface

/* design/aifp_cfg.sv */
// APB configuration registers of the integer field parser
module aifp_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [aifp_pkg::APB_AW-1:0]  paddr,
  input  logic [aifp_pkg::APB_DW-1:0]  pwdata,
  output logic [aifp_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output aifp_pkg::cfg_t               cfg_o
);

  aifp_pkg::cfg_t   cfg_q;
  aifp_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx    = aifp_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // write registers on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_mode   <= aifp_pkg::RST_BASE_MODE;
      cfg_q.width_limit <= aifp_pkg::RST_WIDTH_LIMIT;
      cfg_q.result_size <= aifp_pkg::RST_RESULT_SIZE;
      cfg_q.colon_pair  <= aifp_pkg::RST_COLON_PAIR;
    end else if (wr_en) begin
      unique case (idx)
        aifp_pkg::REG_BASE_MODE:   cfg_q.base_mode   <= pwdata[1:0];
        aifp_pkg::REG_WIDTH_LIMIT: cfg_q.width_limit <= pwdata[16:0];
        aifp_pkg::REG_RESULT_SIZE: cfg_q.result_size <= pwdata[2:0];
        aifp_pkg::REG_COLON_PAIR:  cfg_q.colon_pair  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      aifp_pkg::REG_BASE_MODE:   prdata = 32'(cfg_q.base_mode);
      aifp_pkg::REG_WIDTH_LIMIT: prdata = 32'(cfg_q.width_limit);
      aifp_pkg::REG_RESULT_SIZE: prdata = 32'(cfg_q.result_size);
      aifp_pkg::REG_COLON_PAIR:  prdata = 32'(cfg_q.colon_pair);
      default:                   prdata = '0;
    endcase
  end

endmodule

/* design/aifp_step.sv */
// One character step of the field parser: next state and result
module aifp_step #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  aifp_pkg::cfg_t          cfg_i,
  input  aifp_pkg::ctl_t          ctl_i,
  input  logic [COUNT_BITS-1:0]   dc_i,
  input  logic [COUNT_BITS-1:0]   pc_i,
  input  logic [7:0]              ch_i,
  input  logic                    eoi_i,
  output aifp_pkg::ctl_t          ctl_d_o,
  output logic [COUNT_BITS-1:0]   dc_d_o,
  output logic [COUNT_BITS-1:0]   pc_d_o,
  output logic                    emit_o,
  output aifp_pkg::result_t       res_o
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  localparam logic [4:0] BASE_NONE = 5'd0;
  localparam logic [4:0] BASE_OCT  = 5'd8;
  localparam logic [4:0] BASE_DEC  = 5'd10;
  localparam logic [4:0] BASE_HEX  = 5'd16;

  localparam logic [2:0] SZ_8  = 3'd0;
  localparam logic [2:0] SZ_16 = 3'd1;
  localparam logic [2:0] SZ_64 = 3'd4;

  localparam logic [1:0] MODE_AUTO = 2'd0;
  localparam logic [1:0] MODE_DEC  = 2'd1;
  localparam logic [1:0] MODE_OCT  = 2'd2;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  // digit value of a character, 16 for anything that is no digit
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] d;
    d = 5'd16;
    if (c >= CH_ZERO && c <= CH_NINE) d = 5'(c - CH_ZERO);
    else if (c >= CH_LA && c <= CH_LF) d = 5'(c - CH_LA + 8'd10);
    else if (c >= CH_UA && c <= CH_UF) d = 5'(c - CH_UA + 8'd10);
    return d;
  endfunction

  function automatic logic [4:0] base_of_mode(input logic [1:0] m);
    logic [4:0] b;
    case (m)
      MODE_AUTO: b = BASE_NONE;
      MODE_DEC:  b = BASE_DEC;
      MODE_OCT:  b = BASE_OCT;
      default:   b = BASE_HEX;
    endcase
    return b;
  endfunction

  aifp_pkg::ctl_t          w;
  logic [COUNT_BITS-1:0]   dc_w;
  logic [COUNT_BITS-1:0]   pc_w;
  logic                    fin;
  logic                    took;
  logic                    ended;
  logic                    tk;
  logic                    go;
  logic                    run;
  logic                    is_space;
  logic [4:0]              dig;
  logic [63:0]             scaled;

  assign is_space = (ch_i == CH_SPACE) || (ch_i >= CH_TAB && ch_i <= CH_CR);
  assign dig      = digit_of(ch_i);

  // scale the accumulator by the current base
  always_comb begin
    case (ctl_i.base)
      BASE_OCT: scaled = ctl_i.acc << 3;
      BASE_HEX: scaled = ctl_i.acc << 4;
      default:  scaled = (ctl_i.acc << 3) + (ctl_i.acc << 1);
    endcase
  end

  // next phase and updated field state for this character
  always_comb begin
    w     = ctl_i;
    dc_w  = dc_i;
    pc_w  = pc_i;
    fin   = 1'b0;
    took  = 1'b0;
    ended = 1'b0;
    tk    = 1'b0;
    go    = 1'b1;
    run   = 1'b0;
    if (eoi_i) begin
      fin   = 1'b1;
      ended = 1'b1;
    end else begin
      // skip whitespace, latch base and width, take a sign
      if (w.phase == aifp_pkg::PH_WS) begin
        go = 1'b0;
        if (is_space) begin
          pc_w = sat_inc(pc_w);
        end else begin
          w.width_left = cfg_i.width_limit;
          if (cfg_i.width_limit == '0) begin
            fin = 1'b1;
          end else begin
            w.base  = base_of_mode(cfg_i.base_mode);
            w.phase = aifp_pkg::PH_PREFIX;
            if (ch_i == CH_MINUS || ch_i == CH_PLUS) begin
              w.negative = (ch_i == CH_MINUS);
              pc_w       = sat_inc(pc_w);
              tk         = 1'b1;
            end else begin
              go = 1'b1;
            end
          end
        end
      end
      // prefix handling, falling through to the digit run
      if (go) begin
        unique case (w.phase)
          aifp_pkg::PH_PREFIX: begin
            if (ch_i == CH_ZERO && (w.base == BASE_NONE || w.base == BASE_HEX)) begin
              dc_w    = COUNT_BITS'(1);
              w.phase = aifp_pkg::PH_ZERO;
              tk      = 1'b1;
            end else begin
              if (w.base == BASE_NONE) w.base = BASE_DEC;
              w.phase = aifp_pkg::PH_RUN1;
              run     = 1'b1;
            end
          end
          aifp_pkg::PH_ZERO: begin
            if (ch_i == CH_LX || ch_i == CH_UX) begin
              dc_w    = '0;
              pc_w    = sat_inc(sat_inc(pc_w));
              w.base  = BASE_HEX;
              w.phase = aifp_pkg::PH_RUN1;
              tk      = 1'b1;
            end else begin
              if (w.base == BASE_NONE) w.base = BASE_OCT;
              w.phase = aifp_pkg::PH_RUN1;
              run     = 1'b1;
            end
          end
          aifp_pkg::PH_RUN1, aifp_pkg::PH_RUN2: run = 1'b1;
          default: fin = 1'b1;
        endcase
      end
      // digit run, with an optional colon into the second run
      if (run) begin
        if (dig < w.base) begin
          w.acc = scaled + 64'(dig);
          dc_w  = sat_inc(dc_w);
          tk    = 1'b1;
        end else if (w.phase == aifp_pkg::PH_RUN1 && ch_i == CH_COLON &&
                     cfg_i.colon_pair) begin
          dc_w    = sat_inc(dc_w);
          w.phase = aifp_pkg::PH_RUN2;
          tk      = 1'b1;
        end else begin
          fin = 1'b1;
        end
      end
      // count down the field width on every taken character of a limited field
      if (tk && !w.width_left[aifp_pkg::UNLIM_BIT]) begin
        w.width_left = {1'b0, w.width_left[15:0] - 16'd1};
        if (w.width_left[15:0] == 16'd0) begin
          fin  = 1'b1;
          took = 1'b1;
        end
      end
    end
  end

  logic                    ok;
  logic [63:0]             signed_val;
  logic [63:0]             mask;
  logic [COUNT_BITS:0]     tot;
  logic [COUNT_BITS-1:0]   tot_sat;
  logic [32:0]             tot_w;

  // result fields when the field closes
  always_comb begin
    ok         = (dc_w != '0);
    signed_val = w.negative ? (64'd0 - w.acc) : w.acc;
    case (cfg_i.result_size)
      SZ_8:    mask = 64'h0000_0000_0000_00FF;
      SZ_16:   mask = 64'h0000_0000_0000_FFFF;
      SZ_64:   mask = 64'hFFFF_FFFF_FFFF_FFFF;
      default: mask = 64'h0000_0000_FFFF_FFFF;
    endcase
    tot     = {1'b0, dc_w} + {1'b0, pc_w};
    tot_sat = tot[COUNT_BITS] ? COUNT_MAX : tot[COUNT_BITS-1:0];
    tot_w   = 33'(tot_sat);
    emit_o              = fin;
    res_o.value         = ok ? (signed_val & mask) : 64'd0;
    res_o.matched_count = !ok ? 16'd0 : (tot_w > 33'h0FFFF) ? 16'hFFFF : tot_w[15:0];
    res_o.matched       = ok;
    res_o.consumed      = took;
    res_o.at_end        = ended;
  end

  // next state: start a fresh field after a result
  always_comb begin
    if (fin) begin
      ctl_d_o.phase      = aifp_pkg::PH_WS;
      ctl_d_o.width_left = cfg_i.width_limit;
      ctl_d_o.acc        = '0;
      ctl_d_o.negative   = 1'b0;
      ctl_d_o.base       = BASE_NONE;
      dc_d_o             = '0;
      pc_d_o             = '0;
    end else begin
      ctl_d_o = w;
      dc_d_o  = dc_w;
      pc_d_o  = pc_w;
    end
  end

endmodule

/* design/ascii_integer_field_parser.sv */
// Top level of the scanf-style integer field parser
//
//   channel   dir   word / data                               handshake
//   in_if     in    ch[7:0], end_of_input                     valid/ready
//   out_if    out   value[63:0], matched_count[15:0],         valid/ready
//                   matched, consumed, at_end
//   apb       in    4 registers at byte address 4*i, 32 bits  psel/penable, pready=1
//
// One word per cycle unless the result stalls; a word is registered in ch_q, stepped
// through the parser from there, and its result (if any) is registered in res_q.
// The 64-bit scale-and-add of the accumulator sets the per-cycle path.
// Reset restores register defaults and starts a new field in whitespace skipping.
// A stalled result holds the output register; one more word waits in the input
// register, after which in_if.ready drops until the result is taken.
module ascii_integer_field_parser #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  aifp_in_if.sink                      in_if,
  aifp_out_if.source                   out_if,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [aifp_pkg::APB_AW-1:0]  paddr,
  input  logic [aifp_pkg::APB_DW-1:0]  pwdata,
  output logic [aifp_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);

  aifp_pkg::cfg_t          cfg;
  aifp_pkg::ctl_t          ctl_q;
  aifp_pkg::ctl_t          ctl_d;
  logic [COUNT_BITS-1:0]   dc_q;
  logic [COUNT_BITS-1:0]   dc_d;
  logic [COUNT_BITS-1:0]   pc_q;
  logic [COUNT_BITS-1:0]   pc_d;
  logic                    emit;
  aifp_pkg::result_t       res_d;
  aifp_pkg::result_t       res_q;

  logic                    in_valid_q;
  logic [7:0]              ch_q;
  logic                    eoi_q;
  logic                    out_valid_q;
  logic                    adv;
  logic                    fire;

  aifp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  aifp_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .cfg_i   (cfg),
    .ctl_i   (ctl_q),
    .dc_i    (dc_q),
    .pc_i    (pc_q),
    .ch_i    (ch_q),
    .eoi_i   (eoi_q),
    .ctl_d_o (ctl_d),
    .dc_d_o  (dc_d),
    .pc_d_o  (pc_d),
    .emit_o  (emit),
    .res_o   (res_d)
  );

  // stage advances when the result register is free or being drained
  assign adv         = !out_valid_q || out_if.ready;
  assign fire        = in_valid_q && adv;
  assign in_if.ready = !in_valid_q || adv;

  // input word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      ch_q  <= in_if.ch;
      eoi_q <= in_if.end_of_input;
    end
  end

  // field state, advanced once per stepped word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q.phase      <= aifp_pkg::PH_WS;
      ctl_q.width_left <= aifp_pkg::RST_WIDTH_LIMIT;
      ctl_q.acc        <= '0;
      ctl_q.negative   <= 1'b0;
      ctl_q.base       <= '0;
      dc_q             <= '0;
      pc_q             <= '0;
    end else if (fire) begin
      ctl_q <= ctl_d;
      dc_q  <= dc_d;
      pc_q  <= pc_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= fire && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      res_q <= res_d;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.value         = res_q.value;
  assign out_if.matched_count = res_q.matched_count;
  assign out_if.matched       = res_q.matched;
  assign out_if.consumed      = res_q.consumed;
  assign out_if.at_end        = res_q.at_end;

endmodule

/* design/aifp_checker.sv */
// Port-level checks of the integer field parser, bound to the top level
`include "ascii_integer_field_parser_assert.svh"

module aifp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] value_i,
  input logic [15:0] matched_count_i,
  input logic        matched_i,
  input logic        consumed_i,
  input logic        at_end_i
);

  // a stalled result word holds
  `AIFP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(value_i) && $stable(matched_count_i) && $stable(matched_i) && $stable(consumed_i) && $stable(at_end_i))

  // a failed field reports zero value and zero count
  `AIFP_ASSERT_NOW(a_fail_zero, clk_i, rst_ni, out_valid_i && !matched_i, value_i == 64'd0 && matched_count_i == 16'd0)

  // a converted field always counts at least one character
  `AIFP_ASSERT_NOW(a_match_count, clk_i, rst_ni, out_valid_i && matched_i, matched_count_i != 16'd0)

  // end of input never consumes a character
  `AIFP_ASSERT_NOW(a_end_push, clk_i, rst_ni, out_valid_i && at_end_i, !consumed_i)

endmodule

bind ascii_integer_field_parser aifp_checker u_aifp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_if.valid),
  .out_ready_i     (out_if.ready),
  .value_i         (out_if.value),
  .matched_count_i (out_if.matched_count),
  .matched_i       (out_if.matched),
  .consumed_i      (out_if.consumed),
  .at_end_i        (out_if.at_end)
);
